FILE: hw/rtl/kvtt_pkg.sv
package kvtt_pkg;

  // Buffer limits for stored key and value characters.
  localparam int MaxKeyLen   = 64;
  localparam int MaxValueLen = 256;

  // Field widths.
  localparam int ByteW  = 8;
  localparam int EventW = 4;
  localparam int PosW   = 9;

  // Character codes the tokenizer looks at.
  localparam logic [ByteW-1:0] CharHash    = 8'h23;
  localparam logic [ByteW-1:0] CharEquals  = 8'h3D;
  localparam logic [ByteW-1:0] CharUnder   = 8'h5F;
  localparam logic [ByteW-1:0] CharSpace   = 8'h20;
  localparam logic [ByteW-1:0] CharTab     = 8'h09;
  localparam logic [ByteW-1:0] CharNewline = 8'h0A;
  localparam logic [ByteW-1:0] CharQuote   = 8'h22;
  localparam logic [ByteW-1:0] CharUpperA  = 8'h41;
  localparam logic [ByteW-1:0] CharUpperZ  = 8'h5A;
  localparam logic [ByteW-1:0] CharLowerA  = 8'h61;
  localparam logic [ByteW-1:0] CharLowerZ  = 8'h7A;

  // What the tokenizer did with one byte.
  typedef enum logic [EventW-1:0] {
    EV_SKIP       = 4'd0,
    EV_KEY_CHAR   = 4'd1,
    EV_KEY_CLOSED = 4'd2,
    EV_EQUALS     = 4'd3,
    EV_VALUE_OPEN = 4'd4,
    EV_VALUE_CHAR = 4'd5,
    EV_PAIR_DONE  = 4'd6,
    EV_UNKNOWN    = 4'd7,
    EV_OVERFLOW   = 4'd8,
    EV_HALTED     = 4'd9
  } event_e;

  // One result transaction.
  typedef struct packed {
    event_e             ev;
    logic [ByteW-1:0]   ch;
    logic [PosW-1:0]    pos;
  } result_t;

endpackage

FILE: hw/rtl/key_value_text_tokenizer_top.sv
// An accepted byte is held in the byte register, which feeds the tokenizer logic; its
// result is then written into a two-entry output queue, so input continues while a
// result waits. Throughput: one byte per cycle while the output queue has room.
// Reset (rst_ni low, asynchronous) clears all tokenizer flags, the position counter,
// the sticky error flag, the input register's valid bit and the result queue;
// payload registers are not reset.
module key_value_text_tokenizer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kvtt_pkg::ByteW-1:0]  text_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kvtt_pkg::EventW-1:0] event_res_o,
  output logic [kvtt_pkg::ByteW-1:0]  char_out_o,
  output logic [kvtt_pkg::PosW-1:0]   position_o
);
  import kvtt_pkg::*;

  typedef struct packed {
    logic            in_comment;
    logic            in_key;
    logic            in_value;
    logic            saw_equals;
    logic            awaiting_equals;
    logic [PosW-1:0] pos;
    logic            halted;
  } state_t;

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  state_t           st_q, st_d;
  result_t          res;
  result_t          q_mem [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             q_full, advance, pop, load;

  // Handshake: the byte register moves into the queue whenever the queue has room.
  assign q_full     = (cnt_q == 2'd2);
  assign advance    = in_valid_q && !q_full;
  assign in_stall_o = in_valid_q && q_full;
  assign load       = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  // Input byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= text_byte_i;
    end
  end

  // Tokenizer step for the byte held in the input register.
  always_comb begin
    logic c_ws, c_letter, c_ends_key, c_quote, comment_n;
    c_ws       = (byte_q == CharTab) || (byte_q == CharSpace) || (byte_q == CharNewline);
    c_letter   = ((byte_q >= CharLowerA) && (byte_q <= CharLowerZ)) ||
                 ((byte_q >= CharUpperA) && (byte_q <= CharUpperZ)) ||
                 (byte_q == CharUnder);
    c_ends_key = (byte_q == CharEquals) || (byte_q == CharSpace) || (byte_q == CharTab);
    c_quote    = (byte_q == CharQuote);
    comment_n  = st_q.in_comment;
    st_d       = st_q;
    res.ev     = EV_SKIP;
    res.ch     = '0;
    res.pos    = st_q.pos;

    if (st_q.halted) begin
      res.ev = EV_HALTED;
    end else begin
      // A hash opens a comment anywhere; a newline closes it and is then processed.
      if (byte_q == CharHash) begin
        comment_n = 1'b1;
      end else if ((byte_q == CharNewline) && comment_n) begin
        comment_n = 1'b0;
      end
      st_d.in_comment = comment_n;

      priority if (comment_n) begin
        res.ev = EV_SKIP;
      end else if (c_ws && !(st_q.in_key || st_q.in_value)) begin
        res.ev = EV_SKIP;
      end else if (c_letter && !st_q.in_value && !st_q.in_key && !st_q.awaiting_equals) begin
        if (st_q.pos >= PosW'(MaxKeyLen)) begin
          st_d.halted = 1'b1;
          res.ev      = EV_OVERFLOW;
        end else begin
          st_d.in_key = 1'b1;
          st_d.pos    = st_q.pos + PosW'(1);
          res.ev      = EV_KEY_CHAR;
          res.ch      = byte_q;
        end
      end else if (c_ends_key && !st_q.in_value && st_q.in_key && !st_q.awaiting_equals) begin
        if (st_q.pos >= PosW'(MaxKeyLen)) begin
          st_d.halted = 1'b1;
          res.ev      = EV_OVERFLOW;
        end else begin
          if (byte_q == CharEquals) begin
            st_d.saw_equals = 1'b1;
          end else begin
            st_d.awaiting_equals = 1'b1;
          end
          st_d.in_key = 1'b0;
          st_d.pos    = '0;
          res.ev      = EV_KEY_CLOSED;
        end
      end else if (!st_q.in_value && st_q.in_key && !st_q.awaiting_equals) begin
        if (st_q.pos >= PosW'(MaxKeyLen)) begin
          st_d.halted = 1'b1;
          res.ev      = EV_OVERFLOW;
        end else begin
          st_d.pos = st_q.pos + PosW'(1);
          res.ev   = EV_KEY_CHAR;
          res.ch   = byte_q;
        end
      end else if (c_quote && !st_q.in_key && !st_q.in_value && st_q.saw_equals) begin
        st_d.in_value   = 1'b1;
        st_d.saw_equals = 1'b0;
        res.ev          = EV_VALUE_OPEN;
      end else if (c_quote && !st_q.in_key && st_q.in_value) begin
        if (st_q.pos >= PosW'(MaxValueLen)) begin
          st_d.halted = 1'b1;
          res.ev      = EV_OVERFLOW;
        end else begin
          st_d.in_value = 1'b0;
          st_d.pos      = '0;
          res.ev        = EV_PAIR_DONE;
        end
      end else if (!st_q.in_key && st_q.in_value) begin
        if (st_q.pos >= PosW'(MaxValueLen)) begin
          st_d.halted = 1'b1;
          res.ev      = EV_OVERFLOW;
        end else begin
          st_d.pos = st_q.pos + PosW'(1);
          res.ev   = EV_VALUE_CHAR;
          res.ch   = byte_q;
        end
      end else if ((byte_q == CharEquals) && st_q.awaiting_equals) begin
        st_d.awaiting_equals = 1'b0;
        st_d.saw_equals      = 1'b1;
        res.ev               = EV_EQUALS;
      end else begin
        st_d.halted = 1'b1;
        res.ev      = EV_UNKNOWN;
      end
    end
  end

  // Tokenizer state advances once per byte that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Two-entry result queue: pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (advance) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (advance && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !advance) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      q_mem[wr_ptr_q] <= res;
    end
  end

  // Result transaction at the head of the queue.
  assign out_valid_o = (cnt_q != 2'd0);
  assign event_res_o = q_mem[rd_ptr_q].ev;
  assign char_out_o  = q_mem[rd_ptr_q].ch;
  assign position_o  = q_mem[rd_ptr_q].pos;

endmodule

FILE: hw/rtl/kvtt_checker.sv
module kvtt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [kvtt_pkg::EventW-1:0] event_res_o,
  input logic [kvtt_pkg::ByteW-1:0]  char_out_o,
  input logic [kvtt_pkg::PosW-1:0]   position_o
);
  import kvtt_pkg::*;

  logic out_acc;
  logic error_seen_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // Remember that an error result has gone out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_seen_q <= 1'b0;
    end else if (out_acc && (event_res_o == EV_UNKNOWN || event_res_o == EV_OVERFLOW)) begin
      error_seen_q <= 1'b1;
    end
  end

  // After an error every later result reports the halted tokenizer.
  a_sticky_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && error_seen_q) |-> (event_res_o == EV_HALTED))
    else $error("result after an error is not a halted event");

  // A character is only carried with key and value character events.
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o != EV_KEY_CHAR && event_res_o != EV_VALUE_CHAR)
      |-> (char_out_o == '0))
    else $error("character present on a non-storing event");

  // A stored key character always lies inside the key buffer.
  a_key_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_KEY_CHAR) |-> (position_o < PosW'(MaxKeyLen)))
    else $error("key character stored beyond the key buffer");

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // An accepted input transaction leads to a result on offer once it reaches the queue.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o)
    else $error("no result offered after an accepted input");

endmodule

bind key_value_text_tokenizer_top kvtt_checker u_kvtt_checker (.*);

FILE: tb/kvtt_token_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the tokenizer, predicts the result of every accepted
// input transaction and compares each accepted result against the oldest prediction.
module kvtt_token_checker
  import kvtt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [ByteW-1:0]  text_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [EventW-1:0] event_res_i,
  input  logic [ByteW-1:0]  char_out_i,
  input  logic [PosW-1:0]   position_i,
  output int                fail_count_o,
  output int                pending_o
);

  // Shadow copy of the tokenizer flags and position counter.
  logic            in_comment_q;
  logic            in_key_q;
  logic            in_value_q;
  logic            saw_equals_q;
  logic            awaiting_equals_q;
  logic            halted_q;
  logic [PosW-1:0] char_pos_q;

  result_t token_q[$];
  result_t oldest_token;

  // Advances the shadow state by one byte and returns the event it causes.
  function automatic result_t tokenize_byte(input logic [ByteW-1:0] c);
    result_t         r;
    logic [PosW-1:0] pos;
    logic            is_space;
    logic            key_lead;
    logic            key_end;
    logic            quote;
    pos      = char_pos_q;
    r.ev     = EV_SKIP;
    r.ch     = '0;
    r.pos    = pos;
    is_space = (c == CharTab) || (c == CharSpace) || (c == CharNewline);
    key_lead = (c >= CharLowerA && c <= CharLowerZ) || (c >= CharUpperA && c <= CharUpperZ) ||
               (c == CharUnder);
    key_end  = (c == CharEquals) || (c == CharSpace) || (c == CharTab);
    quote    = (c == CharQuote);

    // Once the error flag is up, nothing else happens.
    if (halted_q) begin
      r.ev = EV_HALTED;
      return r;
    end

    // A hash opens a comment anywhere; a newline closes it and falls through.
    if (c == CharHash) begin
      in_comment_q = 1'b1;
    end else if (c == CharNewline && in_comment_q) begin
      in_comment_q = 1'b0;
    end
    if (in_comment_q) begin
      return r;
    end
    if (is_space && !(in_key_q || in_value_q)) begin
      return r;
    end

    // Key and value rules, tried in priority order.
    if (key_lead && !in_value_q && !in_key_q && !awaiting_equals_q) begin
      if (pos >= MaxKeyLen) begin
        halted_q = 1'b1;
        r.ev     = EV_OVERFLOW;
      end else begin
        in_key_q   = 1'b1;
        char_pos_q = pos + 1'b1;
        r.ev       = EV_KEY_CHAR;
        r.ch       = c;
      end
    end else if (key_end && !in_value_q && in_key_q && !awaiting_equals_q) begin
      if (pos >= MaxKeyLen) begin
        halted_q = 1'b1;
        r.ev     = EV_OVERFLOW;
      end else begin
        if (c == CharEquals) begin
          saw_equals_q = 1'b1;
        end else begin
          awaiting_equals_q = 1'b1;
        end
        in_key_q   = 1'b0;
        char_pos_q = '0;
        r.ev       = EV_KEY_CLOSED;
      end
    end else if (!in_value_q && in_key_q && !awaiting_equals_q) begin
      if (pos >= MaxKeyLen) begin
        halted_q = 1'b1;
        r.ev     = EV_OVERFLOW;
      end else begin
        char_pos_q = pos + 1'b1;
        r.ev       = EV_KEY_CHAR;
        r.ch       = c;
      end
    end else if (quote && !in_key_q && !in_value_q && saw_equals_q) begin
      in_value_q   = 1'b1;
      saw_equals_q = 1'b0;
      r.ev         = EV_VALUE_OPEN;
    end else if (quote && !in_key_q && in_value_q) begin
      if (pos >= MaxValueLen) begin
        halted_q = 1'b1;
        r.ev     = EV_OVERFLOW;
      end else begin
        in_value_q = 1'b0;
        char_pos_q = '0;
        r.ev       = EV_PAIR_DONE;
      end
    end else if (!in_key_q && in_value_q) begin
      if (pos >= MaxValueLen) begin
        halted_q = 1'b1;
        r.ev     = EV_OVERFLOW;
      end else begin
        char_pos_q = pos + 1'b1;
        r.ev       = EV_VALUE_CHAR;
        r.ch       = c;
      end
    end else if (c == CharEquals && awaiting_equals_q) begin
      awaiting_equals_q = 1'b0;
      saw_equals_q      = 1'b1;
      r.ev              = EV_EQUALS;
    end else begin
      halted_q = 1'b1;
      r.ev     = EV_UNKNOWN;
    end
    return r;
  endfunction

  // Compare results first, then queue the prediction for the incoming byte.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q      = 1'b0;
      in_key_q          = 1'b0;
      in_value_q        = 1'b0;
      saw_equals_q      = 1'b0;
      awaiting_equals_q = 1'b0;
      halted_q          = 1'b0;
      char_pos_q        = '0;
      token_q.delete();
      fail_count_o      = 0;
      pending_o         = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (token_q.size() == 0) begin
          $error("result transaction with no prediction waiting: event_res %0d", event_res_i);
          fail_count_o++;
        end else begin
          oldest_token = token_q.pop_front();
          if (event_res_i !== oldest_token.ev) begin
            $error("event_res: expected %0d, got %0d", oldest_token.ev, event_res_i);
            fail_count_o++;
          end
          if (char_out_i !== oldest_token.ch) begin
            $error("char_out: expected %0d, got %0d", oldest_token.ch, char_out_i);
            fail_count_o++;
          end
          if (position_i !== oldest_token.pos) begin
            $error("position: expected %0d, got %0d", oldest_token.pos, position_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        token_q.push_back(tokenize_byte(text_byte_i));
      end
      pending_o = token_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Drives text into the tokenizer and gives the verdict; the checker does the comparing.
module tb;
  import kvtt_pkg::*;

  typedef enum int {
    StallNone,
    StallHalf,
    StallLight,
    StallHeavy
  } stall_mode_e;

  typedef enum int {
    TailUnknown,
    TailKeyOverflow,
    TailValueOverflow
  } tail_kind_e;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [ByteW-1:0]  text_byte;
  logic              out_valid;
  logic              out_stall;
  logic [EventW-1:0] event_res;
  logic [ByteW-1:0]  char_out;
  logic [PosW-1:0]   position;
  int                fail_count;
  int                pending;

  // Sender burst bookkeeping and hold-off handshake with the receiver.
  int burst_left;
  int items_sent;
  int hold_requests;
  int holds_done;

  // Short directed text: skips, a comment, hash and newline inside a key,
  // a key closed by a tab then whitespace before the equals, and an empty value.
  localparam logic [ByteW-1:0] DirectedText [28] = '{
    CharSpace, CharTab, CharNewline, CharHash, 8'hFF, CharQuote, CharNewline,
    CharUpperZ, 8'h00, CharHash, CharEquals, CharNewline, 8'hFF, CharTab,
    CharSpace, CharNewline, CharEquals, CharQuote, 8'h80, CharHash, CharQuote,
    CharNewline, CharQuote, CharUnder, CharLowerZ, CharEquals, CharQuote, CharQuote
  };

  key_value_text_tokenizer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .text_byte_i (text_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .event_res_o (event_res),
    .char_out_o  (char_out),
    .position_o  (position)
  );

  kvtt_token_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .text_byte_i  (text_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .event_res_i  (event_res),
    .char_out_i   (char_out),
    .position_i   (position),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Random byte that is none of the four given codes.
  function automatic logic [ByteW-1:0] pick_byte_except(input logic [ByteW-1:0] a,
                                                         input logic [ByteW-1:0] b,
                                                         input logic [ByteW-1:0] c,
                                                         input logic [ByteW-1:0] d);
    logic [ByteW-1:0] v;
    v = ByteW'($urandom_range(0, 255));
    while (v == a || v == b || v == c || v == d) begin
      v = ByteW'($urandom_range(0, 255));
    end
    return v;
  endfunction

  // Random letter or underscore, which may open a key.
  function automatic logic [ByteW-1:0] pick_key_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) begin
      return ByteW'(CharLowerA + r);
    end else if (r < 52) begin
      return ByteW'(CharUpperA + (r - 26));
    end
    return CharUnder;
  endfunction

  // Offers one byte and waits for the transaction; then maybe idles a while.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // A comment with random content, closed by a newline.
  task automatic send_comment();
    send_byte(CharHash);
    repeat ($urandom_range(0, 6)) send_byte(pick_byte_except(CharNewline, CharNewline,
                                                             CharNewline, CharNewline));
    send_byte(CharNewline);
  endtask

  // Filler between tokens: whitespace runs and comments.
  task automatic send_filler();
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: send_byte(CharSpace);
          1: send_byte(CharTab);
          default: send_byte(CharNewline);
        endcase
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      send_comment();
    end
  endtask

  // A key of the given stored length; an embedded comment stores its newline.
  task automatic send_key(input int len);
    int n;
    send_byte(pick_key_lead());
    n = 1;
    while (n < len) begin
      if ($urandom_range(0, 15) == 0) begin
        send_comment();
      end else begin
        send_byte(pick_byte_except(CharEquals, CharSpace, CharTab, CharHash));
      end
      n++;
    end
  endtask

  // Value body of the given stored length, without the quotes.
  task automatic send_value_body(input int len);
    int n;
    n = 0;
    while (n < len) begin
      if ($urandom_range(0, 15) == 0) begin
        send_comment();
      end else begin
        send_byte(pick_byte_except(CharQuote, CharHash, CharQuote, CharQuote));
      end
      n++;
    end
  endtask

  // A well-formed pair, sometimes with a second key chained after the equals.
  task automatic send_pair(input int key_len, input int value_len);
    int nkeys;
    nkeys = ($urandom_range(0, 5) == 0) ? 2 : 1;
    for (int k = 0; k < nkeys; k++) begin
      send_key((k == 0) ? key_len : $urandom_range(1, 4));
      if ($urandom_range(0, 1)) begin
        send_byte(CharEquals);
      end else begin
        send_byte($urandom_range(0, 1) ? CharSpace : CharTab);
        send_filler();
        send_byte(CharEquals);
      end
    end
    send_filler();
    send_byte(CharQuote);
    send_value_body(value_len);
    send_byte(CharQuote);
  endtask

  // Ends the text with one kind of error, then a few bytes that find it halted.
  task automatic send_error_tail();
    tail_kind_e       kind;
    logic [ByteW-1:0] bad;
    logic             lead;
    kind = tail_kind_e'($urandom_range(0, 2));
    case (kind)
      TailUnknown: begin
        // Not a letter, underscore, whitespace or hash; high bytes included.
        do begin
          bad  = ByteW'($urandom_range(0, 255));
          lead = (bad >= CharLowerA && bad <= CharLowerZ) ||
                 (bad >= CharUpperA && bad <= CharUpperZ) || (bad == CharUnder);
        end while (lead || bad == CharSpace || bad == CharTab || bad == CharNewline ||
                   bad == CharHash);
        send_byte(bad);
      end
      TailKeyOverflow: begin
        send_byte(pick_key_lead());
        repeat (MaxKeyLen) send_byte(pick_byte_except(CharEquals, CharSpace, CharTab,
                                                      CharHash));
      end
      default: begin
        send_byte(pick_key_lead());
        send_byte(CharEquals);
        send_byte(CharQuote);
        send_value_body(MaxValueLen);
        send_byte(CharQuote);
      end
    endcase
    repeat (6) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // Receiver: random stall segments, plus a long hold-off on request.
  initial begin
    stall_mode_e mode;
    int          seg_len;
    out_stall = 1'b0;
    holds_done = 0;
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (79) @(negedge clk);
      end else begin
        mode    = stall_mode_e'($urandom_range(0, 3));
        seg_len = $urandom_range(4, 40);
        repeat (seg_len) begin
          @(negedge clk);
          case (mode)
            StallNone:  out_stall <= 1'b0;
            StallHalf:  out_stall <= 1'($urandom_range(0, 1));
            StallLight: out_stall <= ($urandom_range(0, 3) == 0);
            default:    out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic long_key_done;
    logic long_value_done;
    logic paused;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    text_byte       = '0;
    burst_left      = 0;
    items_sent      = 0;
    hold_requests   = 0;
    long_key_done   = 1'b0;
    long_value_done = 1'b0;
    paused          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedText[i]) send_byte(DirectedText[i]);

    // Random text; the receiver holds off early while the sender keeps going.
    hold_requests++;
    while (items_sent < 480) begin
      if (!paused && items_sent >= 330) begin
        paused = 1'b1;
        wait_drained();
      end
      if (!long_key_done && items_sent >= 100) begin
        long_key_done = 1'b1;
        send_pair(MaxKeyLen - 1, $urandom_range(0, 6));
      end else if (!long_value_done && items_sent >= 180) begin
        long_value_done = 1'b1;
        send_pair($urandom_range(1, 6), MaxValueLen - 1);
      end else if ($urandom_range(0, 7) == 0) begin
        send_filler();
      end else begin
        send_pair($urandom_range(1, 8), $urandom_range(0, 12));
      end
    end

    send_error_tail();
    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/kvtt_pkg.sv
hw/rtl/key_value_text_tokenizer_top.sv
hw/rtl/kvtt_checker.sv
tb/kvtt_token_checker.sv
tb/tb.sv
